@@ src/esns_pkg.sv @@
// ----------------------------------------------------------------------------
// esns_pkg
// Shared types, character codes and decode helpers for the symbol name
// splitter.
// ----------------------------------------------------------------------------
package esns_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CAP_W    = 9;
    localparam int unsigned STATUS_W = 3;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // configuration register indexes
    localparam logic REG_LIB_CAP = 1'b0;
    localparam logic REG_FN_CAP  = 1'b1;

    // part tags
    localparam logic PART_LIB = 1'b0;
    localparam logic PART_FN  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PREFIX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DELIM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_LOW_V      = 8'h76;
    localparam logic [CHAR_W-1:0] CH_LOW_G      = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LOW_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LOW_N      = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_UP_Z       = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_UP_U       = 8'h55;
    localparam logic [CHAR_W-1:0] CH_UP_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOW_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_P      = 8'h70;
    localparam logic [CHAR_W-1:0] CH_LOW_C      = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LOW_D      = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LOW_U      = 8'h75;
    localparam logic [CHAR_W-1:0] CH_LOW_H      = 8'h68;
    localparam logic [CHAR_W-1:0] CH_LOW_S      = 8'h73;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_AT         = 8'h40;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;

    localparam logic [2:0] PREFIX_LAST   = 3'd6;
    localparam logic [2:0] PREFIX_MANGLE = 3'd5;

    typedef enum logic [1:0] {
        PH_PREFIX   = 2'd0,
        PH_LIBRARY  = 2'd1,
        PH_FUNCTION = 2'd2,
        PH_DROP     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_PREFIX = 2'd1,
        ERR_ESCAPE = 2'd2,
        ERR_DELIM  = 2'd3
    } t_err;

    // classified item handed from front to back
    typedef struct packed {
        logic              is_end;
        logic              part;
        logic [CHAR_W-1:0] chr;
        t_err              err;
    } t_cmd;

    function automatic logic prefix_ok(input logic [2:0] pos, input logic [CHAR_W-1:0] b);
        logic ok;
        case (pos)
            3'd0:    ok = (b == CH_UNDERSCORE);
            3'd1:    ok = (b == CH_LOW_V);
            3'd2:    ok = (b == CH_LOW_G);
            3'd3:    ok = (b == CH_LOW_R) || (b == CH_LOW_N);
            3'd4:    ok = (b == CH_UP_Z);
            3'd5:    ok = (b == CH_UP_Z) || (b == CH_UP_U);
            default: ok = (b == CH_UNDERSCORE);
        endcase
        return ok;
    endfunction

    // zero means no valid escape
    function automatic logic [CHAR_W-1:0] unescape(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] ch;
        case (b)
            CH_LOW_A: ch = CH_STAR;
            CH_LOW_P: ch = CH_PLUS;
            CH_LOW_C: ch = CH_COLON;
            CH_LOW_D: ch = CH_DOT;
            CH_LOW_U: ch = CH_UNDERSCORE;
            CH_LOW_H: ch = CH_DASH;
            CH_LOW_S: ch = CH_SPACE;
            CH_UP_Z:  ch = CH_UP_Z;
            CH_UP_A:  ch = CH_AT;
            default:  ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

@@ src/esns_sym_if.sv @@
// ----------------------------------------------------------------------------
// esns_sym_if
// Symbol byte channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface esns_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] sym_char;

    modport source (output valid, output sym_char, input ready);
    modport sink   (input valid, input sym_char, output ready);
endinterface

@@ src/esns_res_if.sv @@
// ----------------------------------------------------------------------------
// esns_res_if
// Result channel: decoded characters and the final status of a symbol.
// ----------------------------------------------------------------------------
interface esns_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_part;
    logic       done_res;
    logic [2:0] status;

    modport source (output valid, output out_char, output out_part,
                    output done_res, output status, input ready);
    modport sink   (input valid, input out_char, input out_part,
                    input done_res, input status, output ready);
endinterface

@@ src/esns_cfg_if.sv @@
// ----------------------------------------------------------------------------
// esns_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface esns_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/escaped_symbol_name_splitter.sv @@
// ----------------------------------------------------------------------------
// escaped_symbol_name_splitter
// Checks the prefix of a mangled symbol name, splits it into library and
// function parts and undoes Z escapes, streaming decoded characters.
// ----------------------------------------------------------------------------
// path: a taken byte's command is written into the command queue, then into the output register
// throughput: one byte per cycle while the command queue is not full, with combinational decode in the front end
// a four-entry command queue lets front and back stall independently
// reset: synchronous, active low; symbol state clears and both capacities
// return to 256 with no clearing pass
module escaped_symbol_name_splitter
    import esns_pkg::*;
#(
    parameter int unsigned MAX_PART_BUFFER = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esns_sym_if.sink   i_sym,
    esns_res_if.source o_res,
    esns_cfg_if.sink   i_cfg
);

    logic [CAP_W-1:0] r_lib_cap;
    logic [CAP_W-1:0] r_fn_cap;

    logic w_accept;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_head_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lib_cap <= CAP_RESET;
            r_fn_cap  <= CAP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_LIB_CAP: r_lib_cap <= i_cfg.data;
                REG_FN_CAP:  r_fn_cap  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_sym.ready = !w_full;
    assign w_accept    = i_sym.valid && !w_full;

    esns_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_sym_char (i_sym.sym_char),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    esns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    esns_back #(
        .MAX_PART_BUFFER (MAX_PART_BUFFER)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lib_cap  (r_lib_cap),
        .i_fn_cap   (r_fn_cap),
        .i_q_empty  (w_empty),
        .i_cmd      (w_head_cmd),
        .o_pop      (w_pop),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_out_char (o_res.out_char),
        .o_out_part (o_res.out_part),
        .o_done_res (o_res.done_res),
        .o_status   (o_res.status)
    );

endmodule

@@ src/esns_front.sv @@
// ----------------------------------------------------------------------------
// esns_front
// Prefix check, part split and escape decode; emits one command per decoded
// character and one per symbol terminator.
// ----------------------------------------------------------------------------
module esns_front
    import esns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_sym_char,
    output logic              o_push,
    output t_cmd              o_cmd
);

    t_phase     r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic       r_esc, n_esc;
    logic       r_fn_esc, n_fn_esc;
    t_err       r_err, n_err;

    logic [CHAR_W-1:0] w_unesc;

    assign w_unesc = unescape(i_sym_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PREFIX;
            r_pos    <= '0;
            r_esc    <= 1'b0;
            r_fn_esc <= 1'b0;
            r_err    <= ERR_NONE;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_esc    <= n_esc;
            r_fn_esc <= n_fn_esc;
            r_err    <= n_err;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_esc    = r_esc;
        n_fn_esc = r_fn_esc;
        n_err    = r_err;
        o_push   = 1'b0;
        o_cmd    = '{is_end: 1'b0, part: PART_LIB, chr: CH_NUL, err: ERR_NONE};

        if (i_accept) begin
            if (i_sym_char == CH_NUL) begin
                // end of symbol: pre-status for the back end, then clear
                o_push       = 1'b1;
                o_cmd.is_end = 1'b1;
                if (r_phase == PH_PREFIX)       o_cmd.err = ERR_PREFIX;
                else if (r_phase == PH_DROP)    o_cmd.err = r_err;
                else if (r_esc)                 o_cmd.err = ERR_ESCAPE;
                else if (r_phase == PH_LIBRARY) o_cmd.err = ERR_DELIM;
                else                            o_cmd.err = ERR_NONE;
                n_phase  = PH_PREFIX;
                n_pos    = '0;
                n_esc    = 1'b0;
                n_fn_esc = 1'b0;
                n_err    = ERR_NONE;
            end else begin
                unique case (r_phase)
                    PH_PREFIX: begin
                        if (!prefix_ok(r_pos, i_sym_char)) begin
                            n_phase = PH_DROP;
                            n_err   = ERR_PREFIX;
                        end else begin
                            if (r_pos == PREFIX_MANGLE) n_fn_esc = (i_sym_char == CH_UP_Z);
                            if (r_pos >= PREFIX_LAST) begin
                                n_phase = PH_LIBRARY;
                                n_esc   = 1'b0;
                            end else begin
                                n_pos = r_pos + 3'd1;
                            end
                        end
                    end
                    PH_LIBRARY, PH_FUNCTION: begin
                        o_cmd.part = (r_phase == PH_FUNCTION) ? PART_FN : PART_LIB;
                        if (r_esc) begin
                            n_esc = 1'b0;
                            if (w_unesc == CH_NUL) begin
                                n_phase = PH_DROP;
                                n_err   = ERR_ESCAPE;
                            end else begin
                                o_push    = 1'b1;
                                o_cmd.chr = w_unesc;
                            end
                        end else if (r_phase == PH_LIBRARY && i_sym_char == CH_UNDERSCORE) begin
                            n_phase = PH_FUNCTION;
                        end else if (i_sym_char == CH_UP_Z
                                     && (r_phase == PH_LIBRARY || r_fn_esc)) begin
                            n_esc = 1'b1;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd.chr = i_sym_char;
                        end
                    end
                    PH_DROP: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ src/esns_queue.sv @@
// ----------------------------------------------------------------------------
// esns_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module esns_queue
    import esns_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue popped while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count did not follow a push");
`endif

endmodule

@@ src/esns_back.sv @@
// ----------------------------------------------------------------------------
// esns_back
// Capacity accounting per part, overflow tracking and the result register.
// ----------------------------------------------------------------------------
module esns_back
    import esns_pkg::*;
#(
    parameter int unsigned MAX_PART_BUFFER = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CAP_W-1:0]    i_lib_cap,
    input  logic [CAP_W-1:0]    i_fn_cap,
    input  logic                i_q_empty,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_out_char,
    output logic                o_out_part,
    output logic                o_done_res,
    output logic [STATUS_W-1:0] o_status
);

    localparam int unsigned CNT_W = $clog2(MAX_PART_BUFFER);
    localparam int unsigned CMP_W = (CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W;

    logic [CNT_W-1:0]    r_lib_cnt, r_fn_cnt;
    logic                r_ovf;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_part;
    logic                r_done;
    logic [STATUS_W-1:0] r_status;

    logic [CMP_W-1:0]    w_cap;
    logic [CMP_W-1:0]    w_next;
    logic [CNT_W-1:0]    w_cnt;
    logic                w_fits;
    logic [STATUS_W-1:0] w_status;

    assign o_pop = !i_q_empty && (!r_out_valid || i_ready);

    always_comb begin
        w_cap = CMP_W'(i_cmd.part ? i_fn_cap : i_lib_cap);
        if (w_cap == '0) w_cap = CMP_W'(1);
        if (w_cap > CMP_W'(MAX_PART_BUFFER)) w_cap = CMP_W'(MAX_PART_BUFFER);
        w_cnt  = i_cmd.part ? r_fn_cnt : r_lib_cnt;
        w_next = CMP_W'(w_cnt) + CMP_W'(1);
        w_fits = (w_next < w_cap);
    end

    always_comb begin
        unique case (i_cmd.err)
            ERR_NONE:   w_status = r_ovf ? ST_OVERFLOW : ST_OK;
            ERR_PREFIX: w_status = ST_BAD_PREFIX;
            ERR_ESCAPE: w_status = ST_BAD_ESCAPE;
            ERR_DELIM:  w_status = ST_NO_DELIM;
            default:    w_status = ST_OK;
        endcase
    end

    // output register holds until taken, reloads on a pop that gives a result
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop && (i_cmd.is_end || w_fits)) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lib_cnt   <= '0;
            r_fn_cnt    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_cmd.is_end) begin
                    r_lib_cnt <= '0;
                    r_fn_cnt  <= '0;
                    r_ovf     <= 1'b0;
                end else if (w_fits) begin
                    if (i_cmd.part) r_fn_cnt <= w_next[CNT_W-1:0];
                    else            r_lib_cnt <= w_next[CNT_W-1:0];
                end else begin
                    // character beyond capacity is dropped
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_char <= i_cmd.is_end ? CH_NUL : i_cmd.chr;
            r_out_part <= i_cmd.is_end ? PART_LIB : i_cmd.part;
            r_done     <= i_cmd.is_end;
            r_status   <= i_cmd.is_end ? w_status : ST_OK;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_out_part = r_out_part;
    assign o_done_res = r_done;
    assign o_status   = r_status;

endmodule

@@ tb/escaped_symbol_name_splitter_test.sv @@
// ----------------------------------------------------------------------------
// escaped_symbol_name_splitter_test
// Streams mangled symbol names into the splitter and checks every decoded
// character and end-of-symbol status against a cycle-free decoder kept in
// the bench. Covers the prefix forms, every escape code, each error, the
// part capacities at their extremes, a long output stall and random
// symbols under random idling on both channels.
// ----------------------------------------------------------------------------
module escaped_symbol_name_splitter_test;
    import esns_pkg::*;

    localparam int PART_BUF_MAX  = 256;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 80;
    localparam int PHASE_BYTES   = 14;

    typedef struct packed {
        logic [7:0] chr;
        logic       part;
        logic       done;
        logic [2:0] status;
    } t_split_result;

    logic clk = 1'b0;
    logic rst_n;

    esns_sym_if sym_ch ();
    esns_res_if res_ch ();
    esns_cfg_if cfg_ch ();

    escaped_symbol_name_splitter #(
        .MAX_PART_BUFFER(PART_BUF_MAX)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_sym  (sym_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decoder state mirrored in the bench
    t_phase     dec_phase;
    logic [2:0] pfx_pos;
    logic       z_pending;
    logic       fn_escaped;
    int         lib_count;
    int         fn_count;
    t_err       err_kind;
    logic       ovf_seen;
    logic [8:0] lib_cap;
    logic [8:0] fn_cap;

    t_split_result pending_results[$];
    logic [7:0]    sym_buf[$];

    int unsigned mismatches   = 0;
    int unsigned bytes_used   = 0;
    int unsigned cycle_count  = 0;
    int unsigned rx_hold      = 0;
    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;
    bit          sym_valid_up = 1'b0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void clear_symbol_state();
        dec_phase  = PH_PREFIX;
        pfx_pos    = 3'd0;
        z_pending  = 1'b0;
        fn_escaped = 1'b0;
        lib_count  = 0;
        fn_count   = 0;
        err_kind   = ERR_NONE;
        ovf_seen   = 1'b0;
    endfunction

    // returns 0 when the byte falls after an error and is ignored
    function automatic bit decode_byte(input logic [7:0] b);
        logic [7:0] ch;
        logic [2:0] st;
        bit         ok;
        bit         emit;
        bit         in_fn;
        int         cap;
        int         used;
        if (b == CH_NUL) begin
            case (dec_phase)
                PH_PREFIX: st = ST_BAD_PREFIX;
                PH_DROP: begin
                    case (err_kind)
                        ERR_PREFIX: st = ST_BAD_PREFIX;
                        ERR_ESCAPE: st = ST_BAD_ESCAPE;
                        ERR_DELIM:  st = ST_NO_DELIM;
                        default:    st = ST_OK;
                    endcase
                end
                default: begin
                    if (z_pending)
                        st = ST_BAD_ESCAPE;
                    else if (dec_phase == PH_LIBRARY)
                        st = ST_NO_DELIM;
                    else
                        st = ST_OK;
                end
            endcase
            if (st == ST_OK && ovf_seen)
                st = ST_OVERFLOW;
            pending_results.push_back('{CH_NUL, PART_LIB, 1'b1, st});
            clear_symbol_state();
            return 1'b1;
        end
        emit = 1'b0;
        ch   = b;
        case (dec_phase)
            PH_DROP: return 1'b0;
            PH_PREFIX: begin
                case (pfx_pos)
                    3'd0:    ok = (b == CH_UNDERSCORE);
                    3'd1:    ok = (b == CH_LOW_V);
                    3'd2:    ok = (b == CH_LOW_G);
                    3'd3:    ok = (b == CH_LOW_R) || (b == CH_LOW_N);
                    3'd4:    ok = (b == CH_UP_Z);
                    3'd5:    ok = (b == CH_UP_Z) || (b == CH_UP_U);
                    default: ok = (b == CH_UNDERSCORE);
                endcase
                if (!ok) begin
                    dec_phase = PH_DROP;
                    err_kind  = ERR_PREFIX;
                end else begin
                    if (pfx_pos == PREFIX_MANGLE)
                        fn_escaped = (b == CH_UP_Z);
                    if (pfx_pos == PREFIX_LAST) begin
                        dec_phase = PH_LIBRARY;
                        z_pending = 1'b0;
                    end else begin
                        pfx_pos = pfx_pos + 3'd1;
                    end
                end
            end
            default: begin
                if (z_pending) begin
                    z_pending = 1'b0;
                    case (b)
                        CH_LOW_A: ch = CH_STAR;
                        CH_LOW_P: ch = CH_PLUS;
                        CH_LOW_C: ch = CH_COLON;
                        CH_LOW_D: ch = CH_DOT;
                        CH_LOW_U: ch = CH_UNDERSCORE;
                        CH_LOW_H: ch = CH_DASH;
                        CH_LOW_S: ch = CH_SPACE;
                        CH_UP_Z:  ch = CH_UP_Z;
                        CH_UP_A:  ch = CH_AT;
                        default:  ch = CH_NUL;
                    endcase
                    if (ch == CH_NUL) begin
                        dec_phase = PH_DROP;
                        err_kind  = ERR_ESCAPE;
                    end else begin
                        emit = 1'b1;
                    end
                end else if (dec_phase == PH_LIBRARY && b == CH_UNDERSCORE) begin
                    dec_phase = PH_FUNCTION;
                end else if (b == CH_UP_Z && (dec_phase == PH_LIBRARY || fn_escaped)) begin
                    z_pending = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
        endcase
        if (emit) begin
            in_fn = (dec_phase == PH_FUNCTION);
            cap   = in_fn ? int'(fn_cap) : int'(lib_cap);
            used  = in_fn ? fn_count : lib_count;
            // zero acts as one, anything above the buffer as the buffer
            if (cap < 1)
                cap = 1;
            if (cap > PART_BUF_MAX)
                cap = PART_BUF_MAX;
            if (used + 1 < cap) begin
                if (in_fn)
                    fn_count++;
                else
                    lib_count++;
                pending_results.push_back('{ch, in_fn ? PART_FN : PART_LIB, 1'b0, ST_OK});
            end else begin
                ovf_seen = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall per transaction, long hold on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned   stall;
        bit            ready_up;
        t_split_result want;
        ready_up = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (rx_hold != 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else if (rx_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 8);
            end
            if (stall != 0) begin
                if (ready_up) begin
                    res_ch.ready <= 1'b0;
                    ready_up = 1'b0;
                end
                repeat (stall) @(posedge clk);
            end
            if (!ready_up) begin
                res_ch.ready <= 1'b1;
                ready_up = 1'b1;
            end
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, char %h part %b done %b status %0d",
                         $time, res_ch.out_char, res_ch.out_part, res_ch.done_res,
                         res_ch.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_char", want.chr, res_ch.out_char);
                check_field("out_part", {7'd0, want.part}, {7'd0, res_ch.out_part});
                check_field("done_res", {7'd0, want.done}, {7'd0, res_ch.done_res});
                check_field("status", {5'd0, want.status}, {5'd0, res_ch.status});
            end
        end
    end

    // ------------------------------------------------------------------
    // symbol side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            if (sym_valid_up)
                sym_ch.valid <= 1'b0;
            sym_valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym_ch.valid    <= 1'b1;
        sym_ch.sym_char <= b;
        sym_valid_up = 1'b1;
        do @(posedge clk); while (sym_ch.ready !== 1'b1);
        if (decode_byte(b))
            bytes_used++;
    endtask

    task automatic send_symbol();
        sym_buf.push_back(CH_NUL);
        while (sym_buf.size() != 0)
            send_byte(sym_buf.pop_front());
    endtask

    task automatic wait_for_idle();
        if (sym_valid_up) begin
            sym_ch.valid <= 1'b0;
            sym_valid_up = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        // bytes that give no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        wait_for_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_LIB_CAP)
            lib_cap = val;
        else
            fn_cap = val;
    endtask

    task automatic set_caps(input logic [8:0] lib_val, input logic [8:0] fn_val);
        write_reg(REG_LIB_CAP, lib_val);
        write_reg(REG_FN_CAP, fn_val);
    endtask

    function automatic logic [7:0] esc_code(input int idx);
        case (idx)
            0:       return CH_LOW_A;
            1:       return CH_LOW_P;
            2:       return CH_LOW_C;
            3:       return CH_LOW_D;
            4:       return CH_LOW_U;
            5:       return CH_LOW_H;
            6:       return CH_LOW_S;
            7:       return CH_UP_Z;
            default: return CH_UP_A;
        endcase
    endfunction

    function automatic logic [7:0] bad_esc_code();
        logic [7:0] c;
        bit         hit;
        if ($urandom_range(0, 3) == 0)
            return CH_UNDERSCORE;
        do begin
            c   = 8'($urandom_range(1, 255));
            hit = 1'b0;
            for (int i = 0; i < 9; i++)
                if (esc_code(i) == c)
                    hit = 1'b1;
        end while (hit);
        return c;
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            sym_buf.push_back(s[i]);
    endfunction

    function automatic void put_prefix(input bit n_form, input bit literal_fn);
        sym_buf.push_back(CH_UNDERSCORE);
        sym_buf.push_back(CH_LOW_V);
        sym_buf.push_back(CH_LOW_G);
        sym_buf.push_back(n_form ? CH_LOW_N : CH_LOW_R);
        sym_buf.push_back(CH_UP_Z);
        sym_buf.push_back(literal_fn ? CH_UP_U : CH_UP_Z);
        sym_buf.push_back(CH_UNDERSCORE);
    endfunction

    // len decoded characters; escapes only where the part undoes them
    function automatic void put_text(input int len, input bit in_fn, input bit escaping);
        logic [7:0] c;
        repeat (len) begin
            if (escaping && $urandom_range(0, 3) == 0) begin
                sym_buf.push_back(CH_UP_Z);
                sym_buf.push_back(esc_code($urandom_range(0, 8)));
            end else begin
                do c = 8'($urandom_range(1, 255));
                while ((escaping && c == CH_UP_Z) || (!in_fn && c == CH_UNDERSCORE));
                sym_buf.push_back(c);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_prefix_forms();
        put_str("_vgrZZ_lib_fn");  send_symbol();
        put_str("_vgnZU_a_b");     send_symbol();
        put_str("_vgrZU__");       send_symbol();
        put_str("_vgnZZ_x_");      send_symbol();
        // lone terminator and a terminator inside the prefix
        send_symbol();
        put_str("_vg");            send_symbol();
        put_str("_vgxZZ_ab_c");    send_symbol();
        put_str("_vgrZZXab_c");    send_symbol();
    endtask

    task automatic test_escape_codes();
        put_str("_vgrZZ_ZaZpZcZdZuZhZsZZZA_ZaZpZcZdZuZhZsZZZA");
        send_symbol();
        // function part copied as is
        put_str("_vgnZU_Zu_Za_Zq");
        send_symbol();
        put_str("_vgrZZ_");
        sym_buf.push_back(8'hff);
        sym_buf.push_back(8'h80);
        sym_buf.push_back(CH_UNDERSCORE);
        sym_buf.push_back(8'h01);
        sym_buf.push_back(8'h7f);
        send_symbol();
    endtask

    task automatic test_error_cases();
        put_str("_vgrZZ_abZqcd_e"); send_symbol();
        put_str("_vgrZZ_aZ_b_c");   send_symbol();  // Z before an underscore is a bad escape, not a delimiter
        put_str("_vgrZZ_abZ");      send_symbol();
        put_str("_vgrZZ_ab_cdZ");   send_symbol();
        put_str("_vgrZU_ab_cdZ");   send_symbol();
        put_str("_vgrZZ_abc");      send_symbol();
        put_str("_vgrZZ_");         send_symbol();
    endtask

    task automatic test_part_capacity();
        // reset capacity holds 255 characters of a part, the next one overflows
        put_prefix(1'b0, 1'b1);
        sym_buf.push_back(CH_UNDERSCORE);
        put_text(256, 1'b1, 1'b0);
        send_symbol();

        set_caps(9'd1, 9'd1);
        put_str("_vgrZZ_a_b");      send_symbol();
        put_str("_vgrZZ__");        send_symbol();

        set_caps(9'd2, 9'd2);
        put_str("_vgrZZ_a_b");      send_symbol();
        put_str("_vgrZZ_ab_");      send_symbol();
        // later errors win over overflow
        put_str("_vgrZZ_abcZq");    send_symbol();
        put_str("_vgrZZ_abc");      send_symbol();
        put_str("_vgrZZ_a_bcZ");    send_symbol();

        set_caps(9'd0, 9'd511);
        put_str("_vgrZZ_a_");       send_symbol();
        put_str("_vgrZU__abcZq");   send_symbol();

        set_caps(9'd256, 9'd256);
    endtask

    task automatic test_input_stall();
        tx_steady = 1'b1;
        rx_hold   = 300;
        put_prefix(1'b0, 1'b0);
        put_text(24, 1'b0, 1'b1);
        sym_buf.push_back(CH_UNDERSCORE);
        put_text(8, 1'b1, 1'b1);
        send_symbol();
        tx_steady = 1'b0;
        wait_for_idle();
    endtask

    task automatic send_random_symbol();
        int         kind;
        bit         lit;
        int         lib_len;
        int         fn_len;
        kind    = $urandom_range(0, 15);
        lit     = 1'($urandom_range(0, 1));
        lib_len = ($urandom_range(0, 29) == 0) ? $urandom_range(12, 20)
                                               : $urandom_range(0, 10);
        fn_len  = ($urandom_range(0, 29) == 0) ? $urandom_range(12, 20)
                                               : $urandom_range(0, 10);
        put_prefix(1'($urandom_range(0, 1)), lit);
        if (kind == 0)
            sym_buf[$urandom_range(0, 6)] = 8'($urandom_range(1, 255));
        put_text(lib_len, 1'b0, 1'b1);
        case (kind)
            1: begin
                sym_buf.push_back(CH_UP_Z);
                sym_buf.push_back(bad_esc_code());
                put_text(3, 1'b0, 1'b1);
                sym_buf.push_back(CH_UNDERSCORE);
            end
            2: ;  // missing delimiter
            3: begin
                sym_buf.delete();
                repeat ($urandom_range(1, 12))
                    sym_buf.push_back(8'($urandom_range(1, 255)));
            end
            4: sym_buf.push_back(CH_UP_Z);
            default: begin
                sym_buf.push_back(CH_UNDERSCORE);
                put_text(fn_len, 1'b1, !lit);
                if (kind == 5) begin
                    sym_buf.push_back(CH_UP_Z);
                end else if (kind == 6) begin
                    sym_buf.push_back(CH_UP_Z);
                    sym_buf.push_back(bad_esc_code());
                    put_text(2, 1'b1, 1'b1);
                end
            end
        endcase
        send_symbol();
    endtask

    task automatic test_random_symbols();
        int unsigned start;
        int          phase_no;
        start    = bytes_used;
        phase_no = 0;
        while (bytes_used - start < RANDOM_BYTES) begin
            if (bytes_used - start >= phase_no * PHASE_BYTES) begin
                case (phase_no)
                    0:       set_caps(9'd256, 9'd256);
                    1:       set_caps(9'd3, 9'd5);
                    2:       set_caps(9'd1, 9'd2);
                    3:       set_caps(9'd0, 9'd511);
                    4:       set_caps(9'd511, 9'd0);
                    5:       set_caps(9'd257, 9'd255);
                    default: set_caps(9'($urandom_range(0, 12)), 9'($urandom_range(0, 511)));
                endcase
                phase_no++;
            end
            // occasional stretches without idling on either side
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            send_random_symbol();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        rst_n           <= 1'b0;
        sym_ch.valid    <= 1'b0;
        sym_ch.sym_char <= CH_NUL;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_LIB_CAP;
        cfg_ch.data     <= CAP_RESET;
        lib_cap = CAP_RESET;
        fn_cap  = CAP_RESET;
        clear_symbol_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prefix_forms();
        test_escape_codes();
        test_error_cases();
        test_part_capacity();
        test_input_stall();
        test_random_symbols();

        wait_for_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/esns_pkg.sv
src/esns_sym_if.sv
src/esns_res_if.sv
src/esns_cfg_if.sv
src/esns_front.sv
src/esns_queue.sv
src/esns_back.sv
src/escaped_symbol_name_splitter.sv
tb/escaped_symbol_name_splitter_test.sv
